@@ rtl/dpa_pkg.sv @@
// Shared constants, codes and control types of the device placement allocator.
package dpa_pkg;

    // Table size and field widths.
    localparam int DEVICES   = 8;
    localparam int SIZE_BITS = 32;
    localparam int DEV_W     = 3;
    localparam int AMT_W     = 48;
    localparam int HANDLE_W  = 35;
    localparam int LAT_W     = 32;
    localparam int SCORE_W   = 16;
    localparam int POL_W     = 3;
    localparam int ROTOR_W   = 4;
    localparam int OP_W      = 3;
    localparam int IDX_W     = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int CNT_W     = $clog2(DEVICES + 1);

    // Operation codes of an input word.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_SELECT = 3'd1,
        OP_ALLOC  = 3'd2,
        OP_AUTO   = 3'd3,
        OP_FREE   = 3'd4
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_TOO_BIG = 2'd3
    } t_status;

    // Selection policies; every other code behaves as most free bytes.
    localparam logic [POL_W-1:0] POL_ROUND_ROBIN = 3'd0;
    localparam logic [POL_W-1:0] POL_MOST_FREE   = 3'd1;
    localparam logic [POL_W-1:0] POL_BEST_SCORE  = 3'd2;
    localparam logic [POL_W-1:0] POL_LOW_LATENCY = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic pick;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_scan;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/dpa_in_if.sv @@
// Input channel of the allocator: one request word with valid and ready.
interface dpa_in_if;
    logic                            valid;
    logic                            ready;
    logic [dpa_pkg::OP_W-1:0]        opcode;
    logic [dpa_pkg::DEV_W-1:0]       device;
    logic [dpa_pkg::AMT_W-1:0]       amount;
    logic [dpa_pkg::HANDLE_W-1:0]    handle_in;
    logic [dpa_pkg::LAT_W-1:0]       latency_ns;
    logic [dpa_pkg::SCORE_W-1:0]     score;

    modport source (output valid, output opcode, output device, output amount,
                    output handle_in, output latency_ns, output score, input ready);
    modport sink   (input valid, input opcode, input device, input amount,
                    input handle_in, input latency_ns, input score, output ready);
endinterface

@@ rtl/dpa_out_if.sv @@
// Output channel of the allocator: one result word with valid and ready.
interface dpa_out_if;
    logic                            valid;
    logic                            ready;
    logic [dpa_pkg::DEV_W-1:0]       chosen_device;
    logic [dpa_pkg::HANDLE_W-1:0]    handle_out;
    logic [1:0]                      status;
    logic [dpa_pkg::AMT_W-1:0]       free_bytes;

    modport source (output valid, output chosen_device, output handle_out,
                    output status, output free_bytes, input ready);
    modport sink   (input valid, input chosen_device, input handle_out,
                    input status, input free_bytes, output ready);
endinterface

@@ rtl/dpa_cfg_if.sv @@
// Configuration channel of the allocator: writes the policy register.
interface dpa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dpa_pkg::POL_W-1:0]       policy;

    modport source (output valid, output policy, input ready);
    modport sink   (input valid, input policy, output ready);
endinterface

@@ rtl/dpa_ctrl.sv @@
// Controller state machine that sequences capture, scan, pick and execute.
module dpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dpa_pkg::t_stat i_stat,
    output dpa_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // A word is taken only when no other is in progress.
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan_step = (r_state == S_SCAN);
    assign o_cmd.pick      = (r_state == S_PICK);
    assign o_cmd.exec      = (r_state == S_EXEC) && i_stat.out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_scan ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/dpa_dpath.sv @@
// Datapath: device table, scanning selector, allocation arithmetic and result register.
module dpa_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dpa_pkg::t_cmd                  i_cmd,
    output dpa_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_valid,
    input  logic [dpa_pkg::POL_W-1:0]      i_cfg_policy,
    input  logic [dpa_pkg::OP_W-1:0]       i_opcode,
    input  logic [dpa_pkg::DEV_W-1:0]      i_device,
    input  logic [dpa_pkg::AMT_W-1:0]      i_amount,
    input  logic [dpa_pkg::HANDLE_W-1:0]   i_handle_in,
    input  logic [dpa_pkg::LAT_W-1:0]      i_latency_ns,
    input  logic [dpa_pkg::SCORE_W-1:0]    i_score,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dpa_pkg::DEV_W-1:0]      o_chosen_device,
    output logic [dpa_pkg::HANDLE_W-1:0]   o_handle_out,
    output logic [1:0]                     o_status,
    output logic [dpa_pkg::AMT_W-1:0]      o_free_bytes
);

    localparam int DEVICES   = dpa_pkg::DEVICES;
    localparam int IDX_W     = dpa_pkg::IDX_W;
    localparam int CNT_W     = dpa_pkg::CNT_W;
    localparam int AMT_W     = dpa_pkg::AMT_W;
    localparam int SIZE_BITS = dpa_pkg::SIZE_BITS;
    localparam int DEV_W     = dpa_pkg::DEV_W;
    localparam int HANDLE_W  = dpa_pkg::HANDLE_W;
    localparam int ROTOR_W   = dpa_pkg::ROTOR_W;

    // Configuration and captured request word.
    logic [dpa_pkg::POL_W-1:0]    r_policy;
    logic [dpa_pkg::OP_W-1:0]     r_op;
    logic [AMT_W-1:0]             r_amount;
    logic [HANDLE_W-1:0]          r_handle;
    logic [dpa_pkg::LAT_W-1:0]    r_lat_in;
    logic [dpa_pkg::SCORE_W-1:0]  r_score_in;
    logic [DEV_W-1:0]             r_target;
    logic                         r_sel_ok;

    // Device table.
    logic [AMT_W-1:0]             r_free  [DEVICES];
    logic [AMT_W-1:0]             r_used  [DEVICES];
    logic [dpa_pkg::LAT_W-1:0]    r_lat   [DEVICES];
    logic [dpa_pkg::SCORE_W-1:0]  r_scr   [DEVICES];
    logic [DEVICES-1:0]           r_present;

    // Scan state.
    logic [IDX_W-1:0]             r_idx;
    logic [DEVICES-1:0]           r_qual;
    logic                         r_found;
    logic [IDX_W-1:0]             r_best;
    logic [AMT_W-1:0]             r_best_free;
    logic [dpa_pkg::LAT_W-1:0]    r_best_lat;
    logic [dpa_pkg::SCORE_W-1:0]  r_best_scr;
    logic [ROTOR_W-1:0]           r_rotor;

    // Result register.
    logic                         r_out_valid;
    logic [DEV_W-1:0]             r_out_dev;
    logic [HANDLE_W-1:0]          r_out_handle;
    dpa_pkg::t_status             r_out_status;
    logic [AMT_W-1:0]             r_out_free;

    // Combinational signals.
    logic [IDX_W-1:0]             rd_idx;
    logic                         e_present;
    logic [AMT_W-1:0]             e_free;
    logic [AMT_W-1:0]             e_used;
    logic [dpa_pkg::LAT_W-1:0]    e_lat;
    logic [dpa_pkg::SCORE_W-1:0]  e_scr;
    logic                         fit;
    logic                         better;
    logic                         too_large;
    logic                         in_range;
    logic [CNT_W-1:0]             qual_cnt;
    logic [ROTOR_W-1:0]           rr_pos;
    logic [CNT_W-1:0]             seen;
    logic                         hit;
    logic [IDX_W-1:0]             rr_idx;
    logic [IDX_W-1:0]             pick_idx;
    logic [SIZE_BITS-1:0]         h_size;
    logic [AMT_W:0]               used_sum;
    logic [AMT_W:0]               free_sum;
    logic                         wr_load;
    logic                         wr_update;
    logic [AMT_W-1:0]             wr_free_val;
    logic [AMT_W-1:0]             wr_used_val;
    logic [DEV_W-1:0]             n_out_dev;
    logic [HANDLE_W-1:0]          n_out_handle;
    dpa_pkg::t_status             n_out_status;
    logic [AMT_W-1:0]             n_out_free;

    // One table read port: the scan index while scanning, the target otherwise.
    assign rd_idx    = i_cmd.scan_step ? r_idx : IDX_W'(r_target);
    assign e_present = r_present[rd_idx];
    assign e_free    = e_present ? r_free[rd_idx] : '0;
    assign e_used    = r_used[rd_idx];
    assign e_lat     = r_lat[rd_idx];
    assign e_scr     = r_scr[rd_idx];
    assign fit       = e_present && (e_free >= r_amount);
    assign too_large = |r_amount[AMT_W-1:SIZE_BITS];
    assign in_range  = (32'(r_target) < DEVICES);
    assign h_size    = r_handle[SIZE_BITS-1:0];

    // Status towards the controller.
    assign o_stat.in_scan   = (i_opcode == dpa_pkg::OP_SELECT) ||
                              ((i_opcode == dpa_pkg::OP_AUTO) &&
                               !(|i_amount[AMT_W-1:SIZE_BITS]));
    assign o_stat.scan_last = (r_idx == IDX_W'(DEVICES - 1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // Policy comparison of the scanned entry against the best so far.
    always_comb begin
        case (r_policy)
            dpa_pkg::POL_BEST_SCORE:  better = e_scr > r_best_scr;
            dpa_pkg::POL_LOW_LATENCY: better = e_lat < r_best_lat;
            default:                  better = e_free > r_best_free;
        endcase
    end

    // Round robin: the qualifying device at the rotor position.
    always_comb begin
        qual_cnt = CNT_W'($countones(r_qual));
        rr_pos   = (8'(r_rotor) >= 8'(qual_cnt)) ? '0 : r_rotor;
        seen     = '0;
        hit      = 1'b0;
        rr_idx   = '0;
        for (int d = 0; d < DEVICES; d++) begin
            if (r_qual[d] && !hit) begin
                if (seen == CNT_W'(rr_pos)) begin
                    rr_idx = IDX_W'(d);
                    hit    = 1'b1;
                end
                seen = seen + 1'b1;
            end
        end
        pick_idx = (r_policy == dpa_pkg::POL_ROUND_ROBIN) ? rr_idx : r_best;
    end

    // Saturating sums for allocation and release.
    assign used_sum = {1'b0, e_used} + {1'b0, r_amount};
    assign free_sum = {1'b0, e_free} + (AMT_W + 1)'(h_size);

    // Execution of the captured word: table update and result word.
    always_comb begin
        n_out_dev    = '0;
        n_out_handle = '0;
        n_out_status = dpa_pkg::ST_OK;
        n_out_free   = '0;
        wr_load      = 1'b0;
        wr_update    = 1'b0;
        wr_free_val  = e_free;
        wr_used_val  = e_used;
        case (r_op)
            dpa_pkg::OP_LOAD: begin
                n_out_dev = r_target;
                if (in_range) begin
                    wr_load    = 1'b1;
                    n_out_free = r_amount;
                end else begin
                    n_out_status = dpa_pkg::ST_ABSENT;
                end
            end
            dpa_pkg::OP_SELECT: begin
                if (r_sel_ok) begin
                    n_out_dev  = r_target;
                    n_out_free = e_free;
                end else begin
                    n_out_status = dpa_pkg::ST_NO_FIT;
                end
            end
            dpa_pkg::OP_ALLOC, dpa_pkg::OP_AUTO: begin
                if (too_large) begin
                    n_out_status = dpa_pkg::ST_TOO_BIG;
                end else begin
                    n_out_dev = r_target;
                    if (!in_range) begin
                        n_out_status = dpa_pkg::ST_ABSENT;
                    end else if (!fit) begin
                        n_out_status = dpa_pkg::ST_ABSENT;
                        n_out_free   = e_free;
                    end else begin
                        wr_update    = 1'b1;
                        wr_free_val  = e_free - r_amount;
                        wr_used_val  = used_sum[AMT_W] ? '1 : used_sum[AMT_W-1:0];
                        n_out_handle = HANDLE_W'({r_target, r_amount[SIZE_BITS-1:0]});
                        n_out_free   = wr_free_val;
                    end
                end
            end
            dpa_pkg::OP_FREE: begin
                n_out_dev = r_target;
                if (!in_range || !e_present) begin
                    n_out_status = dpa_pkg::ST_ABSENT;
                end else begin
                    wr_update   = 1'b1;
                    wr_free_val = free_sum[AMT_W] ? '1 : free_sum[AMT_W-1:0];
                    wr_used_val = (e_used > AMT_W'(h_size)) ? e_used - AMT_W'(h_size) : '0;
                    n_out_free  = wr_free_val;
                end
            end
            default: begin
                n_out_status = dpa_pkg::ST_OK;
            end
        endcase
    end

    // Control state: policy, presence, rotor and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= dpa_pkg::POL_MOST_FREE;
            r_present   <= '0;
            r_rotor     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_policy <= i_cfg_policy;
            end
            if (i_cmd.exec && wr_load) begin
                r_present[IDX_W'(r_target)] <= 1'b1;
            end
            if (i_cmd.pick && (|r_qual) && (r_policy == dpa_pkg::POL_ROUND_ROBIN)) begin
                r_rotor <= rr_pos + 1'b1;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured word, scan registers and chosen device.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_amount   <= i_amount;
            r_handle   <= i_handle_in;
            r_lat_in   <= i_latency_ns;
            r_score_in <= i_score;
            r_target   <= (i_opcode == dpa_pkg::OP_FREE) ?
                          DEV_W'(i_handle_in[HANDLE_W-1:SIZE_BITS]) : i_device;
            r_sel_ok   <= 1'b0;
            r_idx      <= '0;
            r_qual     <= '0;
            r_found    <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (fit) begin
                r_qual[r_idx] <= 1'b1;
                if (!r_found || better) begin
                    r_found     <= 1'b1;
                    r_best      <= r_idx;
                    r_best_free <= e_free;
                    r_best_lat  <= e_lat;
                    r_best_scr  <= e_scr;
                end
            end
        end
        if (i_cmd.pick && (|r_qual)) begin
            r_target <= DEV_W'(pick_idx);
            r_sel_ok <= 1'b1;
        end
    end

    // Table writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_load) begin
            r_free[IDX_W'(r_target)] <= r_amount;
            r_used[IDX_W'(r_target)] <= '0;
            r_lat[IDX_W'(r_target)]  <= r_lat_in;
            r_scr[IDX_W'(r_target)]  <= r_score_in;
        end else if (i_cmd.exec && wr_update) begin
            r_free[IDX_W'(r_target)] <= wr_free_val;
            r_used[IDX_W'(r_target)] <= wr_used_val;
        end
    end

    // Result word payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_dev    <= n_out_dev;
            r_out_handle <= n_out_handle;
            r_out_status <= n_out_status;
            r_out_free   <= n_out_free;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_device = r_out_dev;
    assign o_handle_out    = r_out_handle;
    assign o_status        = r_out_status;
    assign o_free_bytes    = r_out_free;

endmodule

@@ rtl/device_placement_allocator_core.sv @@
// Top level of the device placement allocator: controller, datapath and channels.
//
//   channel  direction  fields
//   i_in     in         opcode, device, amount, handle_in, latency_ns, score
//   o_out    out        chosen_device, handle_out, status, free_bytes
//   i_cfg    in         policy (always ready)
//
// One request word at a time. Load, allocate on a named device, free, oversized and
// undefined words go from acceptance straight to the execute step; select and auto
// allocate first pass through the scan and the pick step, the scan reading one table
// entry per cycle through a single read port.
// A finished result waits in the output register while the next word is accepted.
// Reset is synchronous, active low; it clears presence, rotor and policy (to most free).
// A stalled output holds the next result in its execute step until the register frees.
module device_placement_allocator_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dpa_in_if.sink    i_in,
    dpa_out_if.source o_out,
    dpa_cfg_if.sink   i_cfg
);

    dpa_pkg::t_cmd  cmd;
    dpa_pkg::t_stat stat;
    logic           in_ready;

    // Configuration writes are taken in any cycle.
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // Sequencer.
    dpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Table and arithmetic.
    dpa_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_policy    (i_cfg.policy),
        .i_opcode        (i_in.opcode),
        .i_device        (i_in.device),
        .i_amount        (i_in.amount),
        .i_handle_in     (i_in.handle_in),
        .i_latency_ns    (i_in.latency_ns),
        .i_score         (i_in.score),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_chosen_device (o_out.chosen_device),
        .o_handle_out    (o_out.handle_out),
        .o_status        (o_out.status),
        .o_free_bytes    (o_out.free_bytes)
    );

endmodule

@@ rtl/dpa_checker.sv @@
// Port-level checks of the allocator and the bind that attaches them.
module dpa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [dpa_pkg::DEV_W-1:0]      i_chosen_device,
    input logic [dpa_pkg::HANDLE_W-1:0]   i_handle_out,
    input logic [1:0]                     i_status,
    input logic [dpa_pkg::AMT_W-1:0]      i_free_bytes
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_chosen_device) &&
        $stable(i_handle_out) && $stable(i_status) && $stable(i_free_bytes))
        else $error("result word changed while stalled");

    // Only one request word is in progress at a time.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word accepted while one is in progress");

    // A non-zero handle comes only from a good allocation on the chosen device.
    a_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_handle_out != '0) |->
        (i_status == dpa_pkg::ST_OK) &&
        (i_handle_out[dpa_pkg::HANDLE_W-1:dpa_pkg::SIZE_BITS] == i_chosen_device))
        else $error("handle does not match a good allocation");

    // An oversized request answers with all other fields zero.
    a_too_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == dpa_pkg::ST_TOO_BIG) |->
        (i_chosen_device == '0) && (i_handle_out == '0) && (i_free_bytes == '0))
        else $error("oversized request answered with non-zero fields");

endmodule

bind device_placement_allocator_core dpa_checker u_dpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_chosen_device (o_out.chosen_device),
    .i_handle_out    (o_out.handle_out),
    .i_status        (o_out.status),
    .i_free_bytes    (o_out.free_bytes)
);

@@ dv/testbench.sv @@
// Self-checking testbench of the device placement allocator core.
`timescale 1ns / 1ps

module testbench;

    // Widths and sizes taken from the package.
    localparam int DEVICES   = dpa_pkg::DEVICES;
    localparam int SIZE_BITS = dpa_pkg::SIZE_BITS;
    localparam int OP_W      = dpa_pkg::OP_W;
    localparam int DEV_W     = dpa_pkg::DEV_W;
    localparam int AMT_W     = dpa_pkg::AMT_W;
    localparam int HANDLE_W  = dpa_pkg::HANDLE_W;
    localparam int LAT_W     = dpa_pkg::LAT_W;
    localparam int SCORE_W   = dpa_pkg::SCORE_W;
    localparam int POL_W     = dpa_pkg::POL_W;
    localparam int ROTOR_W   = dpa_pkg::ROTOR_W;

    // Codes that the package leaves unnamed.
    localparam logic [OP_W-1:0]  OP_SPARE_LO   = 3'd5;
    localparam logic [OP_W-1:0]  OP_SPARE_HI   = 3'd7;
    localparam logic [POL_W-1:0] POL_RESIDENCY = 3'd3;
    localparam logic [POL_W-1:0] POL_SPARE_A   = 3'd5;
    localparam logic [POL_W-1:0] POL_SPARE_B   = 3'd6;
    localparam logic [POL_W-1:0] POL_SPARE_C   = 3'd7;

    localparam logic [AMT_W-1:0] AMT_MAX     = {AMT_W{1'b1}};
    localparam logic [AMT_W-1:0] SIZE_LIMIT  = (AMT_W'(1) << SIZE_BITS) - 1;
    localparam int               PHASES      = 8;
    localparam int               PHASE_WORDS = 200;
    localparam int               HOLD_CYCLES = 150;
    localparam int               SETTLE      = 20;

    typedef struct {
        logic [OP_W-1:0]     opcode;
        logic [DEV_W-1:0]    device;
        logic [AMT_W-1:0]    amount;
        logic [HANDLE_W-1:0] handle_in;
        logic [LAT_W-1:0]    latency_ns;
        logic [SCORE_W-1:0]  score;
    } t_request;

    typedef struct {
        logic [DEV_W-1:0]    device;
        logic [HANDLE_W-1:0] handle;
        logic [1:0]          status;
        logic [AMT_W-1:0]    free_bytes;
    } t_placement;

    logic i_clk;
    logic i_rst_n;

    dpa_in_if  in_ch();
    dpa_out_if out_ch();
    dpa_cfg_if cfg_ch();

    device_placement_allocator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Device table as the testbench expects it to be.
    logic [AMT_W-1:0]   avail_bytes [DEVICES];
    logic [AMT_W-1:0]   held_bytes  [DEVICES];
    logic [LAT_W-1:0]   dev_latency [DEVICES];
    logic [SCORE_W-1:0] dev_score   [DEVICES];
    logic               dev_present [DEVICES];
    logic [ROTOR_W-1:0] rotor_pos;
    logic [POL_W-1:0]   active_policy;

    t_request   queued_requests [$];
    t_placement pending_results [$];

    t_request   accepted_word;
    t_request   next_word;
    t_placement predicted_word;
    t_placement got_word;
    t_placement want_word;
    int         tx_gap;
    int         rx_gap;
    int         fault_count;
    logic       idle_on;
    logic       hold_go;
    logic       hold_done;
    int         hold_cnt;
    logic       long_hold;

    assign long_hold = hold_go && !hold_done;

    // A device qualifies when present and holding at least the requested bytes.
    function automatic logic qualifies(input int d, input logic [AMT_W-1:0] size);
        return dev_present[d] && (avail_bytes[d] >= size);
    endfunction

    // Chooses a device under the active policy; round robin also moves the rotor.
    function automatic logic pick_device(input logic [AMT_W-1:0] size,
                                         output logic [DEV_W-1:0] dev);
        int   n;
        int   pos;
        logic found;
        logic better;
        n     = 0;
        pos   = 0;
        found = 1'b0;
        dev   = '0;
        for (int d = 0; d < DEVICES; d++)
            if (qualifies(d, size))
                n++;
        if (n == 0)
            return 1'b0;
        if (active_policy == dpa_pkg::POL_ROUND_ROBIN) begin
            if (rotor_pos >= n)
                rotor_pos = '0;
            for (int d = 0; d < DEVICES; d++) begin
                if (!qualifies(d, size))
                    continue;
                if (pos == rotor_pos) begin
                    dev = DEV_W'(d);
                    break;
                end
                pos++;
            end
            rotor_pos = rotor_pos + 1'b1;
            return 1'b1;
        end
        for (int d = 0; d < DEVICES; d++) begin
            if (!qualifies(d, size))
                continue;
            if (!found) begin
                dev   = DEV_W'(d);
                found = 1'b1;
                continue;
            end
            if (active_policy == dpa_pkg::POL_BEST_SCORE)
                better = dev_score[d] > dev_score[dev];
            else if (active_policy == dpa_pkg::POL_LOW_LATENCY)
                better = dev_latency[d] < dev_latency[dev];
            else
                better = avail_bytes[d] > avail_bytes[dev];
            if (better)
                dev = DEV_W'(d);
        end
        return 1'b1;
    endfunction

    // Takes bytes from one device, or reports it absent or short.
    function automatic t_placement claim_bytes(input logic [DEV_W-1:0] d,
                                               input logic [AMT_W-1:0] size);
        t_placement     r;
        logic [AMT_W:0] sum;
        r = '{d, '0, dpa_pkg::ST_ABSENT, avail_bytes[d]};
        if (!qualifies(d, size))
            return r;
        avail_bytes[d] = avail_bytes[d] - size;
        sum            = {1'b0, held_bytes[d]} + {1'b0, size};
        held_bytes[d]  = sum[AMT_W] ? AMT_MAX : sum[AMT_W-1:0];
        r.handle       = (HANDLE_W'(d) << SIZE_BITS) | HANDLE_W'(size);
        r.status       = dpa_pkg::ST_OK;
        r.free_bytes   = avail_bytes[d];
        return r;
    endfunction

    // Expected result of one accepted request word; updates the table copy.
    function automatic t_placement place_request(input t_request q);
        t_placement          r;
        logic [DEV_W-1:0]    d;
        logic [DEV_W-1:0]    hd;
        logic [AMT_W-1:0]    size;
        logic [AMT_W:0]      sum;
        r = '{'0, '0, dpa_pkg::ST_OK, '0};
        case (q.opcode)
            dpa_pkg::OP_LOAD: begin
                // The device field cannot exceed the table, so a load always lands.
                avail_bytes[q.device] = q.amount;
                held_bytes[q.device]  = '0;
                dev_latency[q.device] = q.latency_ns;
                dev_score[q.device]   = q.score;
                dev_present[q.device] = 1'b1;
                r = '{q.device, '0, dpa_pkg::ST_OK, q.amount};
            end
            dpa_pkg::OP_SELECT: begin
                if (pick_device(q.amount, d))
                    r = '{d, '0, dpa_pkg::ST_OK, avail_bytes[d]};
                else
                    r.status = dpa_pkg::ST_NO_FIT;
            end
            dpa_pkg::OP_ALLOC: begin
                if (q.amount > SIZE_LIMIT)
                    r.status = dpa_pkg::ST_TOO_BIG;
                else
                    r = claim_bytes(q.device, q.amount);
            end
            dpa_pkg::OP_AUTO: begin
                if (q.amount > SIZE_LIMIT) begin
                    r.status = dpa_pkg::ST_TOO_BIG;
                end else begin
                    // With nothing qualifying, fall back to the preferred device.
                    if (!pick_device(q.amount, d))
                        d = q.device;
                    r = claim_bytes(d, q.amount);
                end
            end
            dpa_pkg::OP_FREE: begin
                hd   = q.handle_in[HANDLE_W-1:SIZE_BITS];
                size = AMT_W'(q.handle_in[SIZE_BITS-1:0]);
                if (!dev_present[hd]) begin
                    r = '{hd, '0, dpa_pkg::ST_ABSENT, '0};
                end else begin
                    sum             = {1'b0, avail_bytes[hd]} + {1'b0, size};
                    avail_bytes[hd] = sum[AMT_W] ? AMT_MAX : sum[AMT_W-1:0];
                    held_bytes[hd]  = (held_bytes[hd] > size) ? held_bytes[hd] - size : '0;
                    r = '{hd, '0, dpa_pkg::ST_OK, avail_bytes[hd]};
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Byte counts spread over small, 32-bit, 48-bit and boundary values.
    function automatic logic [AMT_W-1:0] rand_amount();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return AMT_W'($urandom_range(0, 4095));
            4, 5, 6:    return AMT_W'(raw[31:0]);
            7:          return raw[AMT_W-1:0];
            8: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return SIZE_LIMIT;
                    2:       return SIZE_LIMIT + 1'b1;
                    default: return AMT_MAX;
                endcase
            end
            default:    return SIZE_LIMIT + AMT_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic t_request rand_request();
        t_request q;
        int       pick;
        q.device     = DEV_W'($urandom_range(0, DEVICES - 1));
        q.amount     = rand_amount();
        q.handle_in  = HANDLE_W'({$urandom(), $urandom()});
        q.latency_ns = $urandom_range(0, 1) ? LAT_W'($urandom_range(0, 7)) : $urandom();
        q.score      = $urandom_range(0, 1) ? SCORE_W'($urandom_range(0, 3))
                                            : SCORE_W'($urandom());
        // Half of the handles carry a small size so the table does not saturate.
        if ($urandom_range(0, 1))
            q.handle_in = (HANDLE_W'($urandom_range(0, DEVICES - 1)) << SIZE_BITS)
                          | HANDLE_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 15)
            q.opcode = dpa_pkg::OP_LOAD;
        else if (pick < 35)
            q.opcode = dpa_pkg::OP_SELECT;
        else if (pick < 55)
            q.opcode = dpa_pkg::OP_ALLOC;
        else if (pick < 80)
            q.opcode = dpa_pkg::OP_AUTO;
        else if (pick < 95)
            q.opcode = dpa_pkg::OP_FREE;
        else
            q.opcode = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        return q;
    endfunction

    function automatic t_request make_word(input logic [OP_W-1:0] op,
                                           input logic [DEV_W-1:0] dev,
                                           input logic [AMT_W-1:0] amt,
                                           input logic [HANDLE_W-1:0] hnd,
                                           input logic [LAT_W-1:0] lat,
                                           input logic [SCORE_W-1:0] sc);
        t_request q;
        q = '{op, dev, amt, hnd, lat, sc};
        return q;
    endfunction

    function automatic logic [HANDLE_W-1:0] handle_of(input int d,
                                                      input logic [AMT_W-1:0] size);
        return (HANDLE_W'(d) << SIZE_BITS) | HANDLE_W'(size[SIZE_BITS-1:0]);
    endfunction

    // Appends one word to the stimulus queue.
    task automatic enqueue(input t_request q);
        queued_requests = {queued_requests, q};
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #3_000_000;
        $display("[device_placement_allocator_core] ERROR");
        $finish;
    end

    // Request driver: presents queued words and predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                accepted_word = '{in_ch.opcode, in_ch.device, in_ch.amount,
                                  in_ch.handle_in, in_ch.latency_ns, in_ch.score};
                predicted_word  = place_request(accepted_word);
                pending_results = {pending_results, predicted_word};
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 4) == 0) begin
                    in_ch.valid <= 1'b0;
                    tx_gap = $urandom_range(0, 2);
                end else if (queued_requests.size() > 0) begin
                    next_word = queued_requests.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.opcode     <= next_word.opcode;
                    in_ch.device     <= next_word.device;
                    in_ch.amount     <= next_word.amount;
                    in_ch.handle_in  <= next_word.handle_in;
                    in_ch.latency_ns <= next_word.latency_ns;
                    in_ch.score      <= next_word.score;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (long_hold) begin
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
    end

    // Result ready with random short stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_gap = 0;
        end else if (long_hold) begin
            out_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            rx_gap = $urandom_range(0, 2);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Result monitor: compares every accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_word = '{out_ch.chosen_device, out_ch.handle_out, out_ch.status,
                         out_ch.free_bytes};
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: dev %0d handle %h status %0d free %h",
                             got_word.device, got_word.handle, got_word.status,
                             got_word.free_bytes);
            end else begin
                want_word = pending_results.pop_front();
                if (got_word.device !== want_word.device ||
                    got_word.handle !== want_word.handle ||
                    got_word.status !== want_word.status ||
                    got_word.free_bytes !== want_word.free_bytes) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch: expected dev %0d handle %h status %0d free %h,",
                                  " got dev %0d handle %h status %0d free %h"},
                                 want_word.device, want_word.handle, want_word.status,
                                 want_word.free_bytes, got_word.device, got_word.handle,
                                 got_word.status, got_word.free_bytes);
                end
            end
        end
    end

    // Waits until every queued word is taken and every result has come back.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (queued_requests.size() != 0 || in_ch.valid || pending_results.size() != 0);
    endtask

    task automatic write_policy(input logic [POL_W-1:0] pol);
        @(posedge i_clk);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.policy <= pol;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid  <= 1'b0;
        active_policy = pol;
    endtask

    logic [POL_W-1:0] phase_policy [PHASES];

    // Stimulus sequence.
    initial begin
        phase_policy = '{dpa_pkg::POL_ROUND_ROBIN, dpa_pkg::POL_BEST_SCORE,
                         dpa_pkg::POL_LOW_LATENCY, POL_RESIDENCY, POL_SPARE_C,
                         POL_SPARE_A, POL_SPARE_B, dpa_pkg::POL_MOST_FREE};
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = '0;
        in_ch.device     = '0;
        in_ch.amount     = '0;
        in_ch.handle_in  = '0;
        in_ch.latency_ns = '0;
        in_ch.score      = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.policy    = '0;
        idle_on          = 1'b1;
        hold_go          = 1'b0;
        fault_count      = 0;
        tx_gap           = 0;
        rx_gap           = 0;
        for (int d = 0; d < DEVICES; d++) begin
            avail_bytes[d] = '0;
            held_bytes[d]  = '0;
            dev_latency[d] = '0;
            dev_score[d]   = '0;
            dev_present[d] = 1'b0;
        end
        rotor_pos     = '0;
        active_policy = dpa_pkg::POL_MOST_FREE;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset policy, starting from an empty table.
        enqueue(make_word(dpa_pkg::OP_SELECT, DEV_W'(0), '0, '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_ALLOC, DEV_W'(5), '0, '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_AUTO, DEV_W'(6), AMT_W'(1), '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_FREE, DEV_W'(0), '0, {HANDLE_W{1'b1}}, '0, '0));
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            enqueue(make_word(OP_W'(op), DEV_W'(7), AMT_MAX, {HANDLE_W{1'b1}}, '1, '1));
        enqueue(make_word(dpa_pkg::OP_LOAD, DEV_W'(0), AMT_MAX, '0, '1, '1));
        enqueue(make_word(dpa_pkg::OP_LOAD, DEV_W'(7), '0, '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_LOAD, DEV_W'(3), SIZE_LIMIT, '0, LAT_W'(100),
                          16'h0180));
        enqueue(make_word(dpa_pkg::OP_SELECT, DEV_W'(0), AMT_MAX, '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_ALLOC, DEV_W'(3), SIZE_LIMIT + 1'b1, '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_AUTO, DEV_W'(3), AMT_MAX, '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_ALLOC, DEV_W'(3), SIZE_LIMIT, '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_ALLOC, DEV_W'(3), AMT_W'(1), '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_ALLOC, DEV_W'(7), '0, '0, '0, '0));
        // Freeing into a full device saturates its free bytes.
        enqueue(make_word(dpa_pkg::OP_FREE, DEV_W'(0), '0, handle_of(0, SIZE_LIMIT),
                          '0, '0));
        enqueue(make_word(dpa_pkg::OP_FREE, DEV_W'(0), '0, handle_of(3, SIZE_LIMIT),
                          '0, '0));
        enqueue(make_word(dpa_pkg::OP_LOAD, DEV_W'(0), AMT_W'(10), '0, LAT_W'(5),
                          16'h0100));
        enqueue(make_word(dpa_pkg::OP_AUTO, DEV_W'(7), AMT_W'(1) << 31, '0, '0, '0));
        // Nothing fits here, so auto allocation falls back to a short device.
        enqueue(make_word(dpa_pkg::OP_AUTO, DEV_W'(7), SIZE_LIMIT, '0, '0, '0));
        enqueue(make_word(dpa_pkg::OP_SELECT, DEV_W'(0), '0, '0, '0, '0));
        wait_drained();

        // Random phases, one policy each; the receiver stalls long in the second.
        for (int ph = 0; ph < PHASES; ph++) begin
            write_policy(phase_policy[ph]);
            if (ph == PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < PHASE_WORDS; n++)
                enqueue(rand_request());
            if (ph == 1) begin
                @(negedge i_clk);
                hold_go = 1'b1;
            end
            wait_drained();
        end

        repeat (SETTLE) @(negedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("[device_placement_allocator_core] OK");
        else
            $display("[device_placement_allocator_core] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dpa_pkg.sv
rtl/dpa_in_if.sv
rtl/dpa_out_if.sv
rtl/dpa_cfg_if.sv
rtl/dpa_ctrl.sv
rtl/dpa_dpath.sv
rtl/device_placement_allocator_core.sv
rtl/dpa_checker.sv
dv/testbench.sv
